// ===== rtl/isc_pkg.sv =====
// Shared types, codes and constants of the integer stack calculator.
package isc_pkg;

  localparam int WORD_W        = 32;
  localparam int CMD_W         = 3;
  localparam int DEPTH_OUT_W   = 5;
  localparam int ERR_W         = 2;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_FINISH
  } st_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ONE,
    A_ABS_A,
    A_ABS_B,
    A_ITER,
    A_FIX,
    A_DONE
  } alu_st_t;

endpackage

// ===== rtl/isc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module isc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/isc_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
module isc_alu
  import isc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_req_t          req,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output alu_rsp_t          rsp,
  output logic [WORD_W-1:0] result
);

  localparam int CNT_W = $clog2(WORD_W);

  alu_st_t           state_r, state_nxt;
  alu_op_t           op_r, op_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;     // accumulator or remainder
  logic [WORD_W-1:0] y_r, y_nxt;     // multiplicand or dividend / quotient
  logic [WORD_W-1:0] z_r, z_nxt;     // multiplier or divisor
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;

  logic [WORD_W:0]   add_p, add_q, div_t;
  logic              add_sub;
  logic [WORD_W+1:0] add_full;
  logic [WORD_W:0]   add_sum;
  logic              add_carry;

  assign div_t = {x_r, y_r[WORD_W-1]};

  // The single adder that every operation is routed through.
  always_comb begin
    add_p   = '0;
    add_q   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      A_ONE: begin
        add_p   = {y_r[WORD_W-1], y_r};
        add_q   = {z_r[WORD_W-1], z_r};
        add_sub = (op_r == ALU_SUB);
      end
      A_ABS_A: begin
        add_q   = {1'b0, y_r};
        add_sub = 1'b1;
      end
      A_ABS_B: begin
        add_q   = {1'b0, z_r};
        add_sub = 1'b1;
      end
      A_ITER: begin
        if (op_r == ALU_MUL) begin
          add_p = {1'b0, x_r};
          add_q = z_r[0] ? {1'b0, y_r} : '0;
        end else begin
          add_p   = div_t;
          add_q   = {1'b0, z_r};
          add_sub = 1'b1;
        end
      end
      A_FIX: begin
        add_q   = {1'b0, y_r};
        add_sub = 1'b1;
      end
      default: begin
        add_p = '0;
      end
    endcase
    add_full  = {1'b0, add_p} + {1'b0, (add_sub ? ~add_q : add_q)}
              + (WORD_W+2)'(add_sub);
    add_sum   = add_full[WORD_W:0];
    add_carry = add_full[WORD_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          x_nxt   = '0;
          y_nxt   = a;
          z_nxt   = b;
          cnt_nxt = '0;
          neg_nxt = a[WORD_W-1] ^ b[WORD_W-1];
          unique case (req.op)
            ALU_ADD, ALU_SUB: state_nxt = A_ONE;
            ALU_MUL:          state_nxt = A_ITER;
            ALU_DIV:          state_nxt = A_ABS_A;
            default:          state_nxt = A_ONE;
          endcase
        end
      end
      A_ONE: begin
        res_nxt   = add_sum[WORD_W-1:0];
        state_nxt = A_DONE;
      end
      A_ABS_A: begin
        if (y_r[WORD_W-1]) begin
          y_nxt = add_sum[WORD_W-1:0];
        end
        state_nxt = A_ABS_B;
      end
      A_ABS_B: begin
        if (z_r[WORD_W-1]) begin
          z_nxt = add_sum[WORD_W-1:0];
        end
        state_nxt = A_ITER;
      end
      A_ITER: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (op_r == ALU_MUL) begin
          x_nxt = add_sum[WORD_W-1:0];
          y_nxt = {y_r[WORD_W-2:0], 1'b0};
          z_nxt = {1'b0, z_r[WORD_W-1:1]};
        end else begin
          // Subtract only when the shifted remainder reaches the divisor.
          x_nxt = add_carry ? add_sum[WORD_W-1:0] : div_t[WORD_W-1:0];
          y_nxt = {y_r[WORD_W-2:0], add_carry};
        end
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          if (op_r == ALU_MUL) begin
            res_nxt   = add_sum[WORD_W-1:0];
            state_nxt = A_DONE;
          end else begin
            state_nxt = A_FIX;
          end
        end
      end
      A_FIX: begin
        res_nxt   = neg_r ? add_sum[WORD_W-1:0] : y_r;
        state_nxt = A_DONE;
      end
      A_DONE: begin
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  assign rsp.done = (state_r == A_DONE);
  assign result   = res_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == A_IDLE)
    else $error("ALU started while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_ITER && op_r == ALU_DIV) |-> x_r < z_r)
    else $error("division remainder not below divisor");

  a_iter_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_ITER && $past(state_r) != A_ITER) |-> cnt_r == '0)
    else $error("iteration count not cleared on entry");

endmodule

// ===== rtl/integer_stack_calculator.sv =====
// A request is accepted in IDLE, checked in READ and committed in FINISH, where its
// result is registered; an add, subtract, multiply or divide without error also passes
// through CALC. The shared ALU produces one bit of a product or quotient per cycle.
// One request at a time: the next is taken in the cycle after the result is registered,
// and FINISH holds while an earlier result has not been taken by out_ready.
// Synchronous active-low reset empties the stack; stored words are not cleared.
module integer_stack_calculator
  import isc_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CMD_W-1:0]              in_command,
  input  logic signed [WORD_W-1:0]      in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [WORD_W-1:0]      out_result_value,
  output logic [DEPTH_OUT_W-1:0]        out_depth,
  output logic                          out_is_empty,
  output logic [ERR_W-1:0]              out_error_code
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  st_t               state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [WORD_W-1:0] top_r, top_nxt;   // copy of the top entry, valid when not empty

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [CW-1:0]     out_fill_r, out_fill_nxt;
  logic [ERR_W-1:0]  out_err_r, out_err_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] alu_result;

  logic              is_arith;
  logic [CW-1:0]     new_fill;
  logic [WORD_W-1:0] new_value;

  assign is_arith = (cmd_r >= CMD_ADD) && (cmd_r <= CMD_DIV);

  isc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The ALU takes its operands in the read cycle, when the second one is still
  // on the RAM output.
  isc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (top_r),
    .b      (ram_rdata),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    b_r         <= b_nxt;
    res_r       <= res_nxt;
    err_r       <= err_nxt;
    top_r       <= top_nxt;
    out_value_r <= out_value_nxt;
    out_fill_r  <= out_fill_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Outcome of the request once operands and error are known.
  always_comb begin
    new_fill  = fill_r;
    new_value = (fill_r == '0) ? '0 : top_r;
    if (err_r == ERR_OK) begin
      if (cmd_r == CMD_PUSH) begin
        new_fill  = fill_r + CW'(1);
        new_value = val_r;
      end else if (cmd_r == CMD_POP) begin
        new_fill  = fill_r - CW'(1);
        new_value = top_r;
      end else if (is_arith) begin
        new_fill  = fill_r - CW'(1);
        new_value = res_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    fill_nxt      = fill_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fill_nxt  = out_fill_r;
    out_err_nxt   = out_err_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = AW'(fill_r - CW'(2));
    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;

    unique case (cmd_r)
      CMD_SUB: alu_req.op = ALU_SUB;
      CMD_MUL: alu_req.op = ALU_MUL;
      CMD_DIV: alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_command;
          val_nxt   = in_push_value;
          // The entry below the top serves both as second operand and as
          // the new top after a pop.
          ram_re    = (fill_r >= CW'(2));
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        b_nxt   = ram_rdata;
        err_nxt = ERR_OK;
        if (cmd_r == CMD_PUSH) begin
          if (fill_r == CW'(DEPTH)) begin
            err_nxt = ERR_OVER;
          end
        end else if (cmd_r == CMD_POP) begin
          if (fill_r == '0) begin
            err_nxt = ERR_UNDER;
          end
        end else if (is_arith) begin
          if (fill_r < CW'(2)) begin
            err_nxt = ERR_UNDER;
          end else if (cmd_r == CMD_DIV && ram_rdata == '0) begin
            err_nxt = ERR_DIV0;
          end
        end
        if (is_arith && err_nxt == ERR_OK) begin
          alu_req.start = 1'b1;
          state_nxt     = ST_CALC;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_CALC: begin
        if (alu_rsp.done) begin
          res_nxt   = alu_result;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          if (err_r == ERR_OK) begin
            if (cmd_r == CMD_PUSH) begin
              ram_we  = 1'b1;
              top_nxt = val_r;
            end else if (cmd_r == CMD_POP) begin
              top_nxt = b_r;
            end else if (is_arith) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(fill_r - CW'(2));
              ram_wdata = res_r;
              top_nxt   = res_r;
            end
          end
          fill_nxt      = new_fill;
          out_valid_nxt = 1'b1;
          out_value_nxt = new_value;
          out_fill_nxt  = new_fill;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_depth        = DEPTH_OUT_W'(out_fill_r);
  assign out_is_empty     = (out_fill_r == '0);
  assign out_error_code   = out_err_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("stack count beyond capacity");

  a_fill_changes_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (fill_r != $past(fill_r)) |-> $past(state_r) == ST_FINISH)
    else $error("stack count changed outside result commit");

  a_calc_needs_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (is_arith && fill_r >= CW'(2)))
    else $error("ALU busy without two operands");

endmodule
